### hw/rtl/sidt_pkg.sv
package sidt_pkg;

	// Width of the converted value; the bits above it in the input word hold buffer_size.
	localparam int VALUE_WIDTH = 64;

	// Decimal digits needed for any VALUE_WIDTH-bit magnitude (1233/4096 ~ log10(2)).
	localparam int NDIG = ((VALUE_WIDTH * 1233) >> 12) + 1;

	// Double dabble: bits consumed per cycle and number of cycles.
	localparam int BITS_PER_STEP = 4;
	localparam int STEPS = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
	localparam int SH_W = STEPS * BITS_PER_STEP;
	localparam int BCD_W = NDIG * 4;
	localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

	localparam int IDX_W = $clog2(NDIG);
	localparam int LEN_W = $clog2(NDIG + 2);
	localparam int SIZE_W = 8;
	localparam int CMP_W = SIZE_W + 1;

	localparam int CHAR_W = 7;
	localparam int IN_W = 72;
	localparam int OUT_W = 8;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
	localparam logic [CHAR_W-1:0] CHAR_NONE = 7'h00;

	// One classified word handed from the front end to the converter.
	typedef struct packed {
		logic neg;
		logic [VALUE_WIDTH-1:0] mag;
		logic [SIZE_W-1:0] size;
	} item_t;

endpackage

### hw/rtl/sidt_front.sv
module sidt_front
	import sidt_pkg::*;
(
	input  logic            s_axis_tvalid,
	output logic            s_axis_tready,
	input  logic [IN_W-1:0] s_axis_tdata,   // [63:0] value, [71:64] buffer_size
	output logic            push_valid,
	input  logic            push_ready,
	output item_t           push_item
);

	logic [VALUE_WIDTH-1:0] v;

	// Sign split; the negation is unsigned so the most negative value maps to 2^(W-1).
	always_comb begin
		v = s_axis_tdata[VALUE_WIDTH-1:0];
		push_item.neg = v[VALUE_WIDTH-1];
		push_item.mag = v[VALUE_WIDTH-1] ? (~v + 1'b1) : v;
		push_item.size = s_axis_tdata[64 +: SIZE_W];
	end

	assign push_valid = s_axis_tvalid;
	assign s_axis_tready = push_ready;

endmodule

### hw/rtl/sidt_queue.sv
module sidt_queue
	import sidt_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  item_t push_item,
	output logic  pop_valid,
	input  logic  pop_ready,
	output item_t pop_item
);

	item_t mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign push_ready = (count_q != QCNT_W'(QDEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_item = mem_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### hw/rtl/sidt_back.sv
module sidt_back
	import sidt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pop_valid,
	output logic             pop_ready,
	input  item_t            pop_item,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [OUT_W-1:0] m_axis_tdata,   // [6:0] character, [7] zero
	output logic             m_axis_tlast,
	output logic             m_axis_tuser    // [0] error
);

	typedef enum logic [1:0] {
		B_IDLE,
		B_CONV,
		B_LEN,
		B_EMIT
	} bstate_t;

	bstate_t state_q;
	logic [SH_W-1:0] bin_q;
	logic [BCD_W-1:0] bcd_q;
	logic [STEP_W-1:0] step_q;
	logic [IDX_W-1:0] idx_q;
	logic [SIZE_W-1:0] size_q;
	logic neg_q;
	logic sign_pend_q;
	logic err_q;
	logic out_valid_q;
	logic [CHAR_W-1:0] out_char_q;
	logic out_last_q;
	logic out_err_q;

	logic [SH_W-1:0] bin_nx;
	logic [BCD_W-1:0] bcd_nx;
	logic [LEN_W-1:0] nd;
	logic [LEN_W:0] len_c;
	logic len_err;
	logic slot_free;
	logic [3:0] dig;

	// Four shift/add-3 steps per cycle.
	always_comb begin
		bin_nx = bin_q;
		bcd_nx = bcd_q;
		for (int s = 0; s < BITS_PER_STEP; s++) begin
			for (int d = 0; d < NDIG; d++) begin
				if (bcd_nx[d*4 +: 4] >= 4'd5) begin
					bcd_nx[d*4 +: 4] = bcd_nx[d*4 +: 4] + 4'd3;
				end
			end
			bcd_nx = {bcd_nx[BCD_W-2:0], bin_nx[SH_W-1]};
			bin_nx = {bin_nx[SH_W-2:0], 1'b0};
		end
	end

	// Significant digit count, at least one.
	always_comb begin
		nd = LEN_W'(1);
		for (int d = 0; d < NDIG; d++) begin
			if (bcd_q[d*4 +: 4] != 4'd0) begin
				nd = LEN_W'(d + 1);
			end
		end
		len_c = {1'b0, nd} + {{LEN_W{1'b0}}, neg_q};
		// len > size-1 with size >= 2 is len >= size; covers size 0 and 1 too
		len_err = (CMP_W'(len_c) >= CMP_W'(size_q));
	end

	assign dig = bcd_q[{idx_q, 2'b00} +: 4];
	assign slot_free = !out_valid_q || m_axis_tready;
	assign pop_ready = (state_q == B_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			out_valid_q <= 1'b0;
			step_q <= '0;
		end else begin
			// output register: reload when emitting, else drop once taken
			if ((state_q == B_EMIT) && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (pop_valid) begin
						bin_q <= SH_W'(pop_item.mag);
						bcd_q <= '0;
						neg_q <= pop_item.neg;
						size_q <= pop_item.size;
						step_q <= '0;
						state_q <= B_CONV;
					end
				end
				B_CONV: begin
					bin_q <= bin_nx;
					bcd_q <= bcd_nx;
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(STEPS - 1)) begin
						state_q <= B_LEN;
					end
				end
				B_LEN: begin
					err_q <= len_err;
					sign_pend_q <= neg_q;
					idx_q <= IDX_W'(nd - 1'b1);
					state_q <= B_EMIT;
				end
				B_EMIT: begin
					if (slot_free) begin
						if (err_q) begin
							out_char_q <= CHAR_NONE;
							out_last_q <= 1'b1;
							out_err_q <= 1'b1;
							state_q <= B_IDLE;
						end else if (sign_pend_q) begin
							out_char_q <= CHAR_MINUS;
							out_last_q <= 1'b0;
							out_err_q <= 1'b0;
							sign_pend_q <= 1'b0;
						end else begin
							out_char_q <= CHAR_ZERO + {3'b000, dig};
							out_last_q <= (idx_q == '0);
							out_err_q <= 1'b0;
							if (idx_q == '0) begin
								state_q <= B_IDLE;
							end else begin
								idx_q <= idx_q - 1'b1;
							end
						end
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {1'b0, out_char_q};
	assign m_axis_tlast = out_last_q;
	assign m_axis_tuser = out_err_q;

	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_err_q |-> out_last_q && (out_char_q == CHAR_NONE))
		else $error("error word not alone");

	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_err_q |-> (out_char_q == CHAR_MINUS) ||
			((out_char_q >= CHAR_ZERO) && (out_char_q <= CHAR_ZERO + 7'd9)))
		else $error("bad character");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_EMIT) |-> (idx_q <= IDX_W'(NDIG - 1)))
		else $error("digit index out of range");

	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_char_q == CHAR_MINUS) |-> !out_last_q)
		else $error("sign flagged last");

endmodule

### hw/rtl/signed_int_to_decimal_text_core.sv
// Signed integer to decimal text.
// Input stream (s_axis): one word per conversion, tdata[63:0] = value (two's
// complement), tdata[71:64] = buffer_size (bytes including terminator).
// Output stream (m_axis): one ASCII character per word, most significant first,
// '-' leading for negatives; tlast marks the final character of a conversion.
// tuser = error: the text plus terminator would not fit in buffer_size bytes;
// that word is then the only one, with character 0 and tlast set.
// Steps: a conversion loads the word, runs double dabble (4 bits per cycle
// over the 64-bit magnitude), checks length and fit, then emits the characters
// (1 to 20) one after another, each as the output register frees up. The
// converter handles one word at a time; a 2-deep queue after the input stage
// takes up to two further words while it works.
// Reset (arst_n low) empties the queue and the output register at once.
// When the receiver drops tready, the current character holds in the output
// register and the converter waits; once the queue fills, s_axis_tready drops.
module signed_int_to_decimal_text_core
	import sidt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [IN_W-1:0]  s_axis_tdata,   // [63:0] value, [71:64] buffer_size
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [OUT_W-1:0] m_axis_tdata,   // [6:0] character, [7] zero
	output logic             m_axis_tlast,
	output logic             m_axis_tuser    // [0] error
);

	logic push_valid;
	logic push_ready;
	item_t push_item;
	logic pop_valid;
	logic pop_ready;
	item_t pop_item;

	// Sign/magnitude split of the incoming word
	sidt_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.push_valid    (push_valid),
		.push_ready    (push_ready),
		.push_item     (push_item)
	);

	// Decouples intake from the converter
	sidt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	// Binary to BCD, fit check, character emission
	sidt_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.pop_valid     (pop_valid),
		.pop_ready     (pop_ready),
		.pop_item      (pop_item),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule
